@@ src/cca_pkg.sv @@
`timescale 1ns / 1ps
// shared types, constants and field widths for the contiguous cell allocator
package cca_pkg;

  localparam int CELLS_DEF      = 1024;
  localparam int OWNER_BITS_DEF = 8;

  localparam int OWNER_ID_W = 8;
  localparam int SIZE_W     = 11;
  localparam int START_W    = 10;
  localparam int POLICY_W   = 2;
  localparam int ACTIVE_W   = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 16;

  localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
  localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_CELLS = 1'd1;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 11'd1024;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_DECIDE,
    ST_PLACE,
    ST_FREE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic latch;
    logic clear_en;
    logic scan_en;
    logic free_en;
    logic place_en;
    logic cnt_clr;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic scan_last;
    logic free_last;
    logic place_last;
    logic found;
    logic op;
    logic size_zero;
    logic out_free;
  } sts_t;

endpackage

@@ src/contiguous_cell_allocator.sv @@
`timescale 1ns / 1ps
// allocate: one scan pass, then run write
// free: one cell read per cycle, written back as free if its owner matches
// one request at a time through the cell ram (one write, one read port); a result
// may wait in the output register while the next request is taken
// rst_n (synchronous) resets the control registers, then a clearing pass frees
// every cell; requests wait for it to end, configuration writes do not
module contiguous_cell_allocator #(
  parameter int CELLS      = cca_pkg::CELLS_DEF,
  parameter int OWNER_BITS = cca_pkg::OWNER_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [cca_pkg::IN_DATA_W-1:0]   in_tdata,   // owner_id, request_size, zero pad
  input  logic                            in_tuser,   // op
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [cca_pkg::OUT_DATA_W-1:0]  out_tdata,  // granted, start_index, zero pad
  input  logic                            cfg_we,
  input  logic [cca_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cca_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import cca_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cca_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cca_datapath #(
    .CELLS      (CELLS),
    .OWNER_BITS (OWNER_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

@@ src/cca_ram.sv @@
`timescale 1ns / 1ps
// generic single write port ram with registered read
module cca_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/cca_datapath.sv @@
`timescale 1ns / 1ps
// cell store, scan and placement registers, configuration and result register
module cca_datapath #(
  parameter int CELLS      = cca_pkg::CELLS_DEF,
  parameter int OWNER_BITS = cca_pkg::OWNER_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  cca_pkg::cmd_t                   cmd,
  output cca_pkg::sts_t                   sts,
  input  logic [cca_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic                            in_tuser,
  input  logic                            cfg_we,
  input  logic [cca_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cca_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [cca_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import cca_pkg::*;

  localparam int AW = $clog2(CELLS);
  localparam int CW = $clog2(CELLS + 2);
  localparam int LW = (CW > SIZE_W) ? CW : SIZE_W;
  localparam int IW = (OWNER_BITS > OWNER_ID_W) ? OWNER_BITS : OWNER_ID_W;
  localparam int SW = (AW > START_W) ? AW : START_W;
  localparam int DW = OWNER_BITS + 1;

  logic [POLICY_W-1:0]   fit_policy_r;
  logic [ACTIVE_W-1:0]   active_cells_r;
  logic                  op_r, op_nxt;
  logic [OWNER_BITS-1:0] id_r, id_nxt;
  logic [SIZE_W-1:0]     size_r, size_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  p_vld_r, p_vld_nxt;
  logic [CW-1:0]         p_idx_r, p_idx_nxt;
  logic [AW-1:0]         run_start_r, run_start_nxt;
  logic [LW-1:0]         run_len_r, run_len_nxt;
  logic [AW-1:0]         best_start_r, best_start_nxt;
  logic [LW-1:0]         best_len_r, best_len_nxt;
  logic                  found_r, found_nxt;
  logic                  out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [DW-1:0]         ram_wdata;
  logic [DW-1:0]         ram_rdata;
  logic [LW-1:0]         lim;
  logic                  is_free;
  logic                  cell_match;
  logic                  take;
  logic [IW-1:0]         id_ext;
  logic [SW-1:0]         start_ext;

  cca_ram #(
    .WIDTH (DW),
    .DEPTH (CELLS)
  ) u_cell_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cnt_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  // cells beyond the array are never placed
  assign lim = (LW'(active_cells_r) > LW'(CELLS)) ? LW'(CELLS) : LW'(active_cells_r);

  assign is_free    = (LW'(p_idx_r) < lim) && !ram_rdata[DW-1];
  assign cell_match = ram_rdata[DW-1] && (ram_rdata[OWNER_BITS-1:0] == id_r);
  assign take       = !found_r ||
                      ((fit_policy_r == POL_BEST) && (run_len_r < best_len_r)) ||
                      ((fit_policy_r == POL_WORST) && (run_len_r > best_len_r));
  assign id_ext     = IW'(in_tdata[OWNER_ID_W-1:0]);
  assign start_ext  = SW'(best_start_r);

  always_comb begin
    op_nxt         = op_r;
    id_nxt         = id_r;
    size_nxt       = size_r;
    cnt_nxt        = cnt_r;
    p_vld_nxt      = 1'b0;
    p_idx_nxt      = p_idx_r;
    run_start_nxt  = run_start_r;
    run_len_nxt    = run_len_r;
    best_start_nxt = best_start_r;
    best_len_nxt   = best_len_r;
    found_nxt      = found_r;
    ram_we         = 1'b0;
    ram_waddr      = cnt_r[AW-1:0];
    ram_wdata      = '0;

    if (cmd.latch) begin
      op_nxt       = in_tuser;
      id_nxt       = id_ext[OWNER_BITS-1:0];
      size_nxt     = in_tdata[OWNER_ID_W +: SIZE_W];
      cnt_nxt      = '0;
      run_len_nxt  = '0;
      best_len_nxt = '0;
      found_nxt    = 1'b0;
    end

    if (cmd.cnt_clr) begin
      cnt_nxt = '0;
    end

    if (cmd.clear_en) begin
      ram_we  = 1'b1;
      cnt_nxt = cnt_r + CW'(1);
    end

    if (cmd.scan_en) begin
      // read one cell ahead of the run tracker
      if (LW'(cnt_r) <= lim) begin
        p_vld_nxt = 1'b1;
        p_idx_nxt = cnt_r;
        cnt_nxt   = cnt_r + CW'(1);
      end
      if (p_vld_r) begin
        if (is_free) begin
          if (run_len_r == '0) begin
            run_start_nxt = p_idx_r[AW-1:0];
          end
          run_len_nxt = run_len_r + LW'(1);
        end else if (run_len_r != '0) begin
          if ((run_len_r >= LW'(size_r)) && take) begin
            best_start_nxt = run_start_r;
            best_len_nxt   = run_len_r;
            found_nxt      = 1'b1;
          end
          run_len_nxt = '0;
        end
      end
    end

    if (cmd.free_en) begin
      if (cnt_r < CW'(CELLS)) begin
        p_vld_nxt = 1'b1;
        p_idx_nxt = cnt_r;
        cnt_nxt   = cnt_r + CW'(1);
      end
      if (p_vld_r && cell_match) begin
        ram_we    = 1'b1;
        ram_waddr = p_idx_r[AW-1:0];
        ram_wdata = {1'b0, id_r};
      end
    end

    if (cmd.place_en) begin
      ram_we    = 1'b1;
      ram_waddr = best_start_r + cnt_r[AW-1:0];
      ram_wdata = {1'b1, id_r};
      cnt_nxt   = cnt_r + CW'(1);
    end
  end

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    if (cmd.out_load) begin
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = '0;
      out_tdata_nxt[0] = op_r | found_r;
      out_tdata_nxt[START_W:1] = (!op_r && found_r) ? start_ext[START_W-1:0] : '0;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_policy_r   <= POL_FIRST;
      active_cells_r <= ACTIVE_RESET;
      cnt_r          <= '0;
      p_vld_r        <= 1'b0;
      found_r        <= 1'b0;
      run_len_r      <= '0;
      best_len_r     <= '0;
      out_tvalid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FIT_POLICY:   fit_policy_r   <= cfg_wdata[POLICY_W-1:0];
          CFG_ACTIVE_CELLS: active_cells_r <= cfg_wdata[ACTIVE_W-1:0];
          default: ;
        endcase
      end
      cnt_r        <= cnt_nxt;
      p_vld_r      <= p_vld_nxt;
      found_r      <= found_nxt;
      run_len_r    <= run_len_nxt;
      best_len_r   <= best_len_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    id_r         <= id_nxt;
    size_r       <= size_nxt;
    p_idx_r      <= p_idx_nxt;
    run_start_r  <= run_start_nxt;
    best_start_r <= best_start_nxt;
    out_tdata_r  <= out_tdata_nxt;
  end

  assign sts.clear_last = (cnt_r == CW'(CELLS - 1));
  assign sts.scan_last  = p_vld_r && (LW'(p_idx_r) == lim);
  assign sts.free_last  = p_vld_r && (p_idx_r == CW'(CELLS - 1));
  assign sts.place_last = ((LW'(cnt_r) + LW'(1)) == LW'(size_r));
  assign sts.found      = found_r;
  assign sts.op         = op_r;
  assign sts.size_zero  = (size_r == '0);
  assign sts.out_free   = !out_tvalid_r || out_tready;

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

@@ src/cca_ctrl.sv @@
`timescale 1ns / 1ps
// request sequencer: clearing pass, scan, placement, release and result hand-off
module cca_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  cca_pkg::sts_t sts,
  output cca_pkg::cmd_t cmd
);
  import cca_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (sts.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        if (sts.op) state_nxt = ST_FREE;
        else if (sts.size_zero) state_nxt = ST_DONE;
        else state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.scan_last) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_nxt = sts.found ? ST_PLACE : ST_DONE;
      end
      ST_PLACE: begin
        if (sts.place_last) state_nxt = ST_DONE;
      end
      ST_FREE: begin
        if (sts.free_last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_CLEAR:  cmd.clear_en = 1'b1;
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.latch = in_tvalid;
      end
      ST_SCAN:   cmd.scan_en = 1'b1;
      ST_DECIDE: cmd.cnt_clr = 1'b1;
      ST_PLACE:  cmd.place_en = 1'b1;
      ST_FREE:   cmd.free_en = 1'b1;
      ST_DONE:   cmd.out_load = sts.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ tb/tb_contiguous_cell_allocator.sv @@
`timescale 1ns / 1ps
// self-checking testbench for contiguous_cell_allocator: directed table, then random phases
module tb_contiguous_cell_allocator;
  import cca_pkg::*;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;
  localparam logic [POLICY_W-1:0] POL_UNUSED = 2'd3;

  localparam int NUM_PHASES  = 11;
  localparam int PHASE_ITEMS = 24;
  localparam int HOLD_AT     = 40;
  localparam int HOLD_CYCLES = 4000;
  localparam int QUIET_LIMIT = 20000;
  localparam int TAIL_CYCLES = 2200;

  typedef struct packed {
    logic                granted;
    logic [START_W-1:0]  start;
  } grant_t;

  typedef struct {
    bit                     is_cfg;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [CFG_DATA_W-1:0]  reg_val;
    logic                   op;
    logic [OWNER_ID_W-1:0]  owner;
    logic [SIZE_W-1:0]      size;
    bit                     typed;
    grant_t                 want;
  } step_t;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata   = '0;  // owner_id, request_size, zero pad
  logic                   in_tuser   = 1'b0;  // op
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  out_tdata;  // granted, start_index, zero pad
  logic                   cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;

  contiguous_cell_allocator i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // allocator state as the testbench sees it
  bit                     cell_busy   [CELLS_DEF];
  logic [OWNER_ID_W-1:0]  cell_holder [CELLS_DEF];
  logic [POLICY_W-1:0]    fit_rule    = POL_FIRST;
  logic [ACTIVE_W-1:0]    cells_on    = ACTIVE_RESET;

  grant_t pending_grants[$];
  step_t  directed_steps[$];
  logic [OWNER_ID_W-1:0] owner_pool[8];

  int fail_count   = 0;
  int results_seen = 0;
  int quiet_cycles = 0;
  int hold_left    = 0;
  bit hold_taken   = 1'b0;
  logic [15:0] stall_pat = 16'hFFFF;
  int stall_pos    = 0;
  int burst_left   = 1;
  int n_granted    = 0;
  int n_refused    = 0;
  int n_freed      = 0;
  int n_settings   = 0;

  function automatic grant_t serve_request(logic op, logic [OWNER_ID_W-1:0] owner,
                                           logic [SIZE_W-1:0] size);
    grant_t res;
    int lim, run_at, run_len, pick_at, pick_len;
    bit found, free_here, take;
    res = '0;
    if (op == OP_FREE) begin
      // a free sweeps the whole row, not just the active part
      for (int i = 0; i < CELLS_DEF; i++)
        if (cell_busy[i] && cell_holder[i] == owner) cell_busy[i] = 1'b0;
      res.granted = 1'b1;
      return res;
    end
    if (size == 0) return res;
    lim = (cells_on > CELLS_DEF) ? CELLS_DEF : int'(cells_on);
    run_at = 0; run_len = 0; pick_at = 0; pick_len = 0; found = 1'b0;
    // one step past the end closes a run that reaches the last active cell
    for (int i = 0; i <= lim; i++) begin
      free_here = (i < lim) && !cell_busy[i];
      if (free_here) begin
        if (run_len == 0) run_at = i;
        run_len++;
      end else if (run_len > 0) begin
        if (run_len >= size) begin
          take = !found || (fit_rule == POL_BEST && run_len < pick_len) ||
                 (fit_rule == POL_WORST && run_len > pick_len);
          if (take) begin
            pick_at  = run_at;
            pick_len = run_len;
            found    = 1'b1;
          end
        end
        run_len = 0;
      end
    end
    if (!found) return res;
    for (int i = 0; i < size; i++) begin
      cell_busy[pick_at + i]   = 1'b1;
      cell_holder[pick_at + i] = owner;
    end
    res.granted = 1'b1;
    res.start   = pick_at[START_W-1:0];
    return res;
  endfunction

  task automatic add_req(logic op, logic [OWNER_ID_W-1:0] owner, logic [SIZE_W-1:0] size);
    step_t s;
    s = '{default: '0};
    s.op = op; s.owner = owner; s.size = size;
    directed_steps.push_back(s);
  endtask

  task automatic add_known(logic op, logic [OWNER_ID_W-1:0] owner, logic [SIZE_W-1:0] size,
                           logic granted, logic [START_W-1:0] start);
    step_t s;
    s = '{default: '0};
    s.op = op; s.owner = owner; s.size = size;
    s.typed = 1'b1; s.want.granted = granted; s.want.start = start;
    directed_steps.push_back(s);
  endtask

  task automatic add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    step_t s;
    s = '{default: '0};
    s.is_cfg = 1'b1; s.reg_idx = idx; s.reg_val = val;
    directed_steps.push_back(s);
  endtask

  // offer one word and hold it until the block takes it
  task automatic send_req(logic op, logic [OWNER_ID_W-1:0] owner, logic [SIZE_W-1:0] size,
                          bit typed, grant_t typed_res);
    grant_t res;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(IN_DATA_W - SIZE_W - OWNER_ID_W){1'b0}}, size, owner};
    do @(posedge clk); while (!in_tready);
    res = serve_request(op, owner, size);
    pending_grants.push_back(typed ? typed_res : res);
    if (op == OP_FREE) n_freed++;
    else if (res.granted) n_granted++;
    else n_refused++;
  endtask

  task automatic pace_sender();
    int gap, r;
    burst_left--;
    if (burst_left > 0) return;
    burst_left = $urandom_range(1, 8);
    r = $urandom_range(0, 9);
    gap = (r < 4) ? 0 : (r < 8) ? $urandom_range(1, 12) : $urandom_range(50, 600);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_FIT_POLICY) fit_rule = val[POLICY_W-1:0];
    else cells_on = val[ACTIVE_W-1:0];
    n_settings++;
  endtask

  // receiver: random ready pattern, one long hold-off once traffic is flowing
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (!hold_taken && results_seen == HOLD_AT) begin
      hold_taken <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= stall_pat[stall_pos];
      stall_pos  <= (stall_pos + 1) % 16;
      if (stall_pos == 15) stall_pat <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
    end
  end

  always @(posedge clk) begin : result_check
    grant_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen <= results_seen + 1;
      if (pending_grants.size() == 0) begin
        $error("result word %h with no request pending", out_tdata);
        fail_count++;
      end else begin
        want = pending_grants.pop_front();
        if (out_tdata[0] !== want.granted) begin
          $error("granted: expected %0d, got %0d", want.granted, out_tdata[0]);
          fail_count++;
        end
        if (out_tdata[START_W:1] !== want.start) begin
          $error("start_index: expected %0d, got %0d", want.start, out_tdata[START_W:1]);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int eff, r, pick;
    logic                  op;
    logic [OWNER_ID_W-1:0] owner;
    logic [SIZE_W-1:0]     size;
    logic [CFG_DATA_W-1:0] act;

    for (int i = 0; i < CELLS_DEF; i++) begin
      cell_busy[i]   = 1'b0;
      cell_holder[i] = '0;
    end
    owner_pool[0] = 8'd0;
    owner_pool[1] = 8'd255;
    for (int i = 2; i < 8; i++) owner_pool[i] = OWNER_ID_W'($urandom_range(1, 254));

    // reset state, first fit over the whole row
    add_known(OP_ALLOC, 8'd0,   11'd1,    1'b1, 10'd0);
    add_known(OP_ALLOC, 8'd255, 11'd0,    1'b0, 10'd0);     // zero size
    add_known(OP_ALLOC, 8'd1,   11'd2047, 1'b0, 10'd0);     // larger than the row
    add_known(OP_ALLOC, 8'd1,   11'd1024, 1'b0, 10'd0);     // cell 0 is taken
    add_known(OP_ALLOC, 8'd2,   11'd1023, 1'b1, 10'd1);
    add_known(OP_FREE,  8'd0,   11'd0,    1'b1, 10'd0);
    add_known(OP_FREE,  8'd2,   11'd0,    1'b1, 10'd0);
    add_known(OP_ALLOC, 8'd5,   11'd1023, 1'b1, 10'd0);
    add_known(OP_ALLOC, 8'd6,   11'd1,    1'b1, 10'd1023);  // last cell
    add_known(OP_FREE,  8'd77,  11'h7FF,  1'b1, 10'd0);     // owner holds nothing
    add_known(OP_FREE,  8'd5,   11'd0,    1'b1, 10'd0);
    add_known(OP_FREE,  8'd6,   11'd0,    1'b1, 10'd0);
    // holes of 3 and 2 cells in front of a big tail
    add_req(OP_ALLOC, 8'd10, 11'd5);
    add_req(OP_ALLOC, 8'd11, 11'd3);
    add_req(OP_ALLOC, 8'd12, 11'd10);
    add_req(OP_ALLOC, 8'd13, 11'd2);
    add_req(OP_ALLOC, 8'd14, 11'd20);
    add_req(OP_FREE,  8'd11, 11'd0);
    add_req(OP_FREE,  8'd13, 11'd0);
    add_cfg(CFG_FIT_POLICY, CFG_DATA_W'(POL_BEST));
    add_req(OP_ALLOC, 8'd20, 11'd2);
    add_cfg(CFG_FIT_POLICY, CFG_DATA_W'(POL_WORST));
    add_req(OP_ALLOC, 8'd21, 11'd2);
    add_cfg(CFG_FIT_POLICY, CFG_DATA_W'(POL_UNUSED));      // acts as first fit
    add_req(OP_ALLOC, 8'd22, 11'd1);
    add_cfg(CFG_ACTIVE_CELLS, 11'd0);
    add_known(OP_ALLOC, 8'd23, 11'd1, 1'b0, 10'd0);         // no usable cell
    add_cfg(CFG_ACTIVE_CELLS, 11'd2047);                    // clipped to the row
    add_req(OP_ALLOC, 8'd24, 11'd982);
    add_cfg(CFG_ACTIVE_CELLS, 11'd30);
    add_req(OP_FREE,  8'd14, 11'd0);                        // run straddles the active edge
    add_req(OP_ALLOC, 8'd25, 11'd10);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_steps[k]) begin
      if (directed_steps[k].is_cfg) begin
        write_reg(directed_steps[k].reg_idx, directed_steps[k].reg_val);
      end else begin
        send_req(directed_steps[k].op, directed_steps[k].owner, directed_steps[k].size,
                 directed_steps[k].typed, directed_steps[k].want);
        pace_sender();
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      pick = $urandom_range(0, 9);
      if (p == 0 || pick == 0) act = 11'd1024;
      else if (pick == 1) act = CFG_DATA_W'($urandom_range(1025, 2047));
      else if (pick == 2) act = 11'd1;
      else if (pick == 3 && p > 5) act = 11'd0;
      else act = CFG_DATA_W'($urandom_range(8, 160));
      write_reg(CFG_FIT_POLICY, CFG_DATA_W'($urandom_range(0, 3)));
      write_reg(CFG_ACTIVE_CELLS, act);
      eff = (cells_on > CELLS_DEF) ? CELLS_DEF : int'(cells_on);
      if (eff < 2) eff = 2;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        op    = ($urandom_range(0, 9) < 3) ? OP_FREE : OP_ALLOC;
        owner = ($urandom_range(0, 9) == 0) ? OWNER_ID_W'($urandom_range(0, 255))
                                            : owner_pool[$urandom_range(0, 7)];
        r = $urandom_range(0, 19);
        if (r == 0) size = 11'd0;
        else if (r == 1) size = SIZE_W'($urandom_range(1025, 2047));
        else if (r == 2) size = SIZE_W'($urandom_range(1, 1024));
        else size = SIZE_W'($urandom_range(1, (eff / 6 > 1) ? eff / 6 : 2));
        send_req(op, owner, size, 1'b0, '0);
        pace_sender();
      end
    end

    in_tvalid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_grants.size() != 0) begin
      $error("%0d results never arrived", pending_grants.size());
      fail_count++;
    end

    $display("covered %0d requests: %0d placed, %0d refused, %0d frees",
             n_granted + n_refused + n_freed, n_granted, n_refused, n_freed);
    $display("over %0d register writes, including all policies and active-count extremes",
             n_settings);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/cca_pkg.sv
src/cca_ram.sv
src/cca_datapath.sv
src/cca_ctrl.sv
src/contiguous_cell_allocator.sv
tb/tb_contiguous_cell_allocator.sv
